@@ src/mclp_pkg.sv @@
// Types, constants and character helpers for the motion command line parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mclp_pkg;

    typedef enum logic [3:0] {
        PH_TOK0  = 4'd0,
        PH_TOK1  = 4'd1,
        PH_WS1   = 4'd2,
        PH_SIGN1 = 4'd3,
        PH_DIG1  = 4'd4,
        PH_WS2   = 4'd5,
        PH_SIGN2 = 4'd6,
        PH_DIG2  = 4'd7,
        PH_DONE  = 4'd8,
        PH_FAIL  = 4'd15
    } phase_t;

    localparam logic [1:0] KIND_STOP      = 2'd0;
    localparam logic [1:0] KIND_HEARTBEAT = 2'd1;
    localparam logic [1:0] KIND_MOVE      = 2'd2;
    localparam logic [1:0] KIND_TURN      = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_R     = 8'h52;

    typedef struct packed {
        phase_t      phase;
        logic        neg;
        logic [31:0] first_num;
        logic [31:0] second_num;
        logic [1:0]  pos;
        logic [7:0]  first_char;
        logic [7:0]  second_char;
        logic        trimmed;
        logic        content_ended;
    } scan_state_t;

    // ok sits in the lowest bit
    typedef struct packed {
        logic [31:0] speed;
        logic [31:0] amount;
        logic        direction;
        logic [1:0]  kind;
        logic        ok;
    } result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_dig(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

@@ src/mclp_scanner.sv @@
// Byte scanner: token, sign and decimal accumulator state for one line.
// Depends on mclp_pkg; gives the post-byte state view to the decoder.
`timescale 1ns / 1ps
`default_nettype none

module mclp_scanner (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     step_i,
    input  wire [7:0]               byte_i,
    input  wire                     last_i,
    output mclp_pkg::scan_state_t   view_o
);
    import mclp_pkg::*;

    scan_state_t state_reg;
    scan_state_t state_next;

    logic        ws;
    logic        dig;
    logic        sgn;
    logic        neg_b;
    logic [31:0] dval;

    function automatic logic [31:0] add_digit(input logic [31:0] m, input logic [31:0] d);
        logic [35:0] v;
        v = {1'b0, m, 3'b000} + {3'b000, m, 1'b0} + {4'b0000, d};
        if (v > 36'h080000000) begin
            v = 36'h080000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] finish_num(input logic [31:0] m, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = 32'd0 - m;
        end else if (m > 32'h7FFFFFFF) begin
            r = 32'h7FFFFFFF;
        end else begin
            r = m;
        end
        return r;
    endfunction

    always_comb begin
        state_next = state_reg;
        ws    = is_ws(byte_i);
        dig   = is_dig(byte_i);
        sgn   = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);
        neg_b = (byte_i == CH_MINUS);
        dval  = {28'd0, byte_i[3:0]};
        if (!state_reg.content_ended) begin
            if (byte_i == CH_NUL) begin
                state_next.content_ended = 1'b1;
            end else begin
                case (state_reg.pos)
                    2'd0: begin
                        state_next.first_char = byte_i;
                        state_next.pos        = 2'd1;
                    end
                    2'd1: begin
                        state_next.second_char = byte_i;
                        state_next.pos         = 2'd2;
                    end
                    default: ;
                endcase
                if (!ws) begin
                    state_next.trimmed = 1'b1;
                end
                case (state_reg.phase)
                    PH_TOK0: begin
                        if (!ws) state_next.phase = PH_TOK1;
                    end
                    PH_TOK1: begin
                        state_next.phase = PH_WS1;
                    end
                    PH_WS1: begin
                        if (!ws) begin
                            if (sgn) begin
                                state_next.neg       = neg_b;
                                state_next.first_num = 32'd0;
                                state_next.phase     = PH_SIGN1;
                            end else if (dig) begin
                                state_next.neg       = 1'b0;
                                state_next.first_num = dval;
                                state_next.phase     = PH_DIG1;
                            end else begin
                                state_next.phase = PH_FAIL;
                            end
                        end
                    end
                    PH_SIGN1: begin
                        if (dig) begin
                            state_next.first_num = dval;
                            state_next.phase     = PH_DIG1;
                        end else begin
                            state_next.phase = PH_FAIL;
                        end
                    end
                    PH_DIG1: begin
                        if (dig) begin
                            state_next.first_num = add_digit(state_reg.first_num, dval);
                        end else begin
                            state_next.first_num = finish_num(state_reg.first_num,
                                                              state_reg.neg);
                            if (ws) begin
                                state_next.phase = PH_WS2;
                            end else if (sgn) begin
                                state_next.neg        = neg_b;
                                state_next.second_num = 32'd0;
                                state_next.phase      = PH_SIGN2;
                            end else begin
                                state_next.phase = PH_FAIL;
                            end
                        end
                    end
                    PH_WS2: begin
                        if (!ws) begin
                            if (sgn) begin
                                state_next.neg        = neg_b;
                                state_next.second_num = 32'd0;
                                state_next.phase      = PH_SIGN2;
                            end else if (dig) begin
                                state_next.neg        = 1'b0;
                                state_next.second_num = dval;
                                state_next.phase      = PH_DIG2;
                            end else begin
                                state_next.phase = PH_FAIL;
                            end
                        end
                    end
                    PH_SIGN2: begin
                        if (dig) begin
                            state_next.second_num = dval;
                            state_next.phase      = PH_DIG2;
                        end else begin
                            state_next.phase = PH_FAIL;
                        end
                    end
                    PH_DIG2: begin
                        if (dig) begin
                            state_next.second_num = add_digit(state_reg.second_num, dval);
                        end else begin
                            state_next.second_num = finish_num(state_reg.second_num,
                                                               state_reg.neg);
                            state_next.phase      = PH_DONE;
                        end
                    end
                    PH_DONE: ;
                    default: begin
                        state_next.phase = PH_FAIL;
                    end
                endcase
            end
        end
        // close a second number still open at the end of the line
        if (last_i && state_next.phase == PH_DIG2) begin
            state_next.second_num = finish_num(state_next.second_num, state_next.neg);
            state_next.phase      = PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_i && last_i)) begin
            state_reg <= '0;
        end else if (step_i) begin
            state_reg <= state_next;
        end
    end

    assign view_o = state_next;

endmodule

`default_nettype wire

@@ src/mclp_decoder.sv @@
// Command decoder: maps the end-of-line scanner state to one result item.
// Depends on mclp_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module mclp_decoder (
    input  wire mclp_pkg::scan_state_t view_i,
    output mclp_pkg::result_t          result_o
);
    import mclp_pkg::*;

    logic has2;
    logic nums_ok;

    always_comb begin
        result_o = '0;
        has2     = view_i.pos[1];
        nums_ok  = (view_i.phase == PH_DONE);
        if (view_i.trimmed) begin
            if (view_i.first_char == CH_S && (!has2 || is_ws(view_i.second_char))) begin
                result_o.ok   = 1'b1;
                result_o.kind = KIND_STOP;
            end else if (view_i.first_char == CH_H && has2 && view_i.second_char == CH_B) begin
                result_o.ok   = 1'b1;
                result_o.kind = KIND_HEARTBEAT;
            end else if (view_i.first_char == CH_F || view_i.first_char == CH_B) begin
                if (nums_ok) begin
                    result_o.ok        = 1'b1;
                    result_o.kind      = KIND_MOVE;
                    result_o.direction = (view_i.first_char == CH_F);
                    result_o.amount    = view_i.first_num;
                    result_o.speed     = view_i.second_num;
                end
            end else if (view_i.first_char == CH_T && has2 &&
                         (view_i.second_char == CH_L || view_i.second_char == CH_R)) begin
                if (nums_ok) begin
                    result_o.ok        = 1'b1;
                    result_o.kind      = KIND_TURN;
                    result_o.direction = (view_i.second_char == CH_L);
                    result_o.amount    = view_i.first_num;
                    result_o.speed     = view_i.second_num;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ src/motion_command_line_parser.sv @@
// A line's result item is registered as its last byte leaves the input register.
// Throughput: one byte item per cycle; stalls only while a result waits on m_tready.
// The scanner state update and decode sit between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers and returns the scanner
// to the start of a line; scanner state also clears after each line.
// Depends on mclp_pkg, mclp_scanner and mclp_decoder.
`timescale 1ns / 1ps
`default_nettype none

module motion_command_line_parser (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] line_byte
    input  wire         s_tlast,   // line_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata    // [0] ok, [2:1] kind, [3] direction,
                                   // [35:4] amount, [67:36] speed, rest zero
);
    import mclp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic        adv;
    scan_state_t view;
    result_t     res;

    assign adv      = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mclp_scanner u_scanner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (adv),
        .byte_i  (in_byte_reg),
        .last_i  (in_last_reg),
        .view_o  (view)
    );

    mclp_decoder u_decoder (
        .view_i   (view),
        .result_o (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_last_reg) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_last_reg |=> m_tvalid)
        else $error("line end did not produce a result item");

    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !(adv && in_last_reg) |=> !m_tvalid)
        else $error("result item appeared without a line end");

    a_fail_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_data_reg.ok |-> out_data_reg.kind == KIND_STOP &&
        !out_data_reg.direction && out_data_reg.amount == 32'd0 &&
        out_data_reg.speed == 32'd0)
        else $error("failed line carries nonzero fields");

    a_no_stall_on_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !in_last_reg |-> adv)
        else $error("mid-line byte stalled");
`endif

endmodule

`default_nettype wire
